>>> hdl/scba_pkg.sv
// Shared types and constants for the size class block allocator.
// Used by the configuration registers, the allocation core and the top level.
`default_nettype none

package scba_pkg;

  // Number of block size registers, and so the most classes that can be served.
  localparam int NUM_REGS = 6;
  localparam int BYTES_W  = 16;
  localparam int CFG_IDX_W = 3;

  // Operation carried by a request beat.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_NO_BLOCK  = 2'd1,
    ST_FREED     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  // Block size of every class, class 0 in the lowest slot.
  typedef logic [NUM_REGS-1:0][BYTES_W-1:0] class_bytes_t;

  localparam class_bytes_t RESET_BYTES = {
    16'd512, 16'd256, 16'd128, 16'd64, 16'd32, 16'd16
  };

  // One request beat.
  typedef struct packed {
    logic         mode;
    logic [15:0]  req_size;
    logic [2:0]   free_class;
    logic [3:0]   free_index;
  } req_t;

  // One result beat.
  typedef struct packed {
    status_t      status;
    logic [2:0]   block_class;
    logic [3:0]   block_index;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/size_class_block_allocator_top.sv
// Size class block allocator, top level with request and result registers.
// Requests are held in the request register and results in the result register;
// one request per cycle unless a stalled result blocks it; size compares and the
// free-block search finish in the single logic stage between the two registers.
// Reset clears every busy bit, loads the default block sizes and empties both
// registers; no clearing pass follows.
// Depends on scba_pkg, scba_cfg_regs and scba_alloc_core.
`default_nettype none

module size_class_block_allocator_top #(
  parameter int NUM_CLASSES      = 6,
  parameter int BLOCKS_PER_CLASS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [scba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scba_pkg::BYTES_W-1:0]    cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire scba_pkg::req_t                  in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output scba_pkg::result_t                    out_data
);
  import scba_pkg::*;

  class_bytes_t class_bytes;
  logic         req_valid;
  req_t         req;
  logic         fire;
  result_t      result;

  scba_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .class_bytes (class_bytes)
  );

  // The held request is processed when the result register is free or draining.
  assign fire     = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !fire;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req <= in_data;
    end
  end

  scba_alloc_core #(
    .NUM_CLASSES      (NUM_CLASSES),
    .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
  ) u_alloc_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .req         (req),
    .class_bytes (class_bytes),
    .result      (result)
  );

  // Result register: holds a beat until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

>>> hdl/scba_cfg_regs.sv
// Block size registers of the six size classes, written through a plain write port.
// Depends on scba_pkg for widths and reset values.
`default_nettype none

module scba_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [scba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scba_pkg::BYTES_W-1:0]    cfg_data,
  output scba_pkg::class_bytes_t               class_bytes
);
  import scba_pkg::*;

  // Each register takes the data when its index is written; other indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      class_bytes <= RESET_BYTES;
    end else if (cfg_we) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        if (cfg_index == CFG_IDX_W'(r)) begin
          class_bytes[r] <= cfg_data;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/scba_alloc_core.sv
// Allocation core: per-class busy bitmaps, size compares and lowest-free-block search.
// Depends on scba_pkg for the request, result and block size types.
`default_nettype none

module scba_alloc_core #(
  parameter int NUM_CLASSES      = 6,
  parameter int BLOCKS_PER_CLASS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    fire,
  input  wire scba_pkg::req_t          req,
  input  wire scba_pkg::class_bytes_t  class_bytes,
  output scba_pkg::result_t            result
);
  import scba_pkg::*;

  localparam int SERVED = (NUM_CLASSES < NUM_REGS) ? NUM_CLASSES : NUM_REGS;
  localparam int CLS_W  = (SERVED > 1) ? $clog2(SERVED) : 1;
  localparam int IDX_W  = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;

  logic [SERVED-1:0][BLOCKS_PER_CLASS-1:0] busy_map;
  logic [SERVED-1:0][BLOCKS_PER_CLASS-1:0] busy_map_next;

  logic [SERVED-1:0][BLOCKS_PER_CLASS-1:0] free_bits;
  logic [SERVED-1:0]                       eligible;
  logic                                    alloc_hit;
  logic [CLS_W-1:0]                        sel_cls;
  logic [BLOCKS_PER_CLASS-1:0]             sel_row;
  logic [BLOCKS_PER_CLASS-1:0]             grant_mask;
  logic [IDX_W-1:0]                        grant_idx;
  logic [5:0]                              grant_idx6;

  logic                                    free_ok;
  logic                                    free_hit;
  logic [CLS_W-1:0]                        free_cls;
  logic [5:0]                              free_idx6;
  logic [BLOCKS_PER_CLASS-1:0]             free_mask;
  logic [BLOCKS_PER_CLASS-1:0]             free_row;

  // A class can serve the request when it is large enough and has a free block.
  always_comb begin
    for (int c = 0; c < SERVED; c++) begin
      free_bits[c] = ~busy_map[c];
      eligible[c]  = (req.req_size <= class_bytes[c]) && (|free_bits[c]);
    end
  end

  // First eligible class wins.
  always_comb begin
    alloc_hit = 1'b0;
    sel_cls   = '0;
    for (int c = SERVED - 1; c >= 0; c--) begin
      if (eligible[c]) begin
        alloc_hit = 1'b1;
        sel_cls   = CLS_W'(c);
      end
    end
  end

  // Isolate the lowest free block of the chosen class and encode its index.
  always_comb begin
    sel_row = '0;
    for (int c = 0; c < SERVED; c++) begin
      if (sel_cls == CLS_W'(c)) begin
        sel_row = free_bits[c];
      end
    end
    grant_mask = sel_row & (~sel_row + 1'b1);
    grant_idx  = '0;
    for (int b = 0; b < BLOCKS_PER_CLASS; b++) begin
      if (grant_mask[b]) begin
        grant_idx = grant_idx | IDX_W'(b);
      end
    end
    grant_idx6 = 6'(grant_idx);
  end

  // A free names a block that exists and is busy.
  always_comb begin
    free_cls  = req.free_class[CLS_W-1:0];
    free_idx6 = 6'(req.free_index);
    free_ok   = (req.free_class < 3'(SERVED) || SERVED == 8) &&
                (7'(free_idx6) < 7'(BLOCKS_PER_CLASS));
    for (int b = 0; b < BLOCKS_PER_CLASS; b++) begin
      free_mask[b] = (free_idx6 == 6'(b));
    end
    free_row = '0;
    for (int c = 0; c < SERVED; c++) begin
      if (free_cls == CLS_W'(c)) begin
        free_row = busy_map[c];
      end
    end
    free_hit = free_ok && (|(free_row & free_mask));
  end

  // Result of the request in the input register.
  always_comb begin
    result.status      = ST_NO_BLOCK;
    result.block_class = '0;
    result.block_index = '0;
    if (req.mode == MODE_ALLOC) begin
      if (alloc_hit) begin
        result.status      = ST_GRANTED;
        result.block_class = 3'(sel_cls);
        result.block_index = grant_idx6[3:0];
      end
    end else begin
      if (free_hit) begin
        result.status      = ST_FREED;
        result.block_class = req.free_class;
        result.block_index = req.free_index;
      end else begin
        result.status      = ST_NOT_ALLOC;
      end
    end
  end

  // Busy map update: set the granted bit or clear the freed bit.
  always_comb begin
    busy_map_next = busy_map;
    if (fire) begin
      for (int c = 0; c < SERVED; c++) begin
        if (req.mode == MODE_ALLOC && alloc_hit && sel_cls == CLS_W'(c)) begin
          busy_map_next[c] = busy_map[c] | grant_mask;
        end
        if (req.mode == MODE_FREE && free_hit && free_cls == CLS_W'(c)) begin
          busy_map_next[c] = busy_map[c] & ~free_mask;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_map <= '0;
    end else begin
      busy_map <= busy_map_next;
    end
  end

endmodule

`default_nettype wire
